// File: rtl/skac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package skac_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS          = 24;
    localparam int DB_TABLE_ENTRIES_DEF = 1024;
    localparam int CFG_W                = 25;
    localparam int CFG_IDX_W            = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_INV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WET       = 3'd7;

    // Register reset values
    localparam logic [14:0] RST_THRESHOLD = 15'h7400;
    localparam logic [12:0] RST_KNEE      = 13'd1536;
    localparam logic [21:0] RST_KNEE_INV  = 22'd5461;
    localparam logic [15:0] RST_SLOPE     = 16'hB333;
    localparam logic [23:0] RST_ATTACK    = 24'd16733653;
    localparam logic [23:0] RST_RELEASE   = 24'd16774303;
    localparam logic [24:0] RST_MAKEUP    = 25'd1398101;
    localparam logic [16:0] RST_WET       = 17'd65536;

    // Arithmetic constants
    localparam logic [31:0] DB_PER_OCTAVE_Q16 = 32'd394566;
    localparam logic [31:0] OCTAVE_PER_DB_Q24 = 32'd2786635;
    localparam logic [14:0] FLOOR_DB_MAG_Q8   = 15'd30720;
    localparam logic [12:0] KNEE_MIN_Q8       = 13'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic signed [SAMPLE_BITS-1:0] key_left;
        logic signed [SAMPLE_BITS-1:0] key_right;
        logic                          use_key;
        logic                          block_end;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic [15:0]                   reduction_now;
        logic [15:0]                   block_max_reduction;
    } t_out_word;

    // Multiplier operand selection
    typedef enum logic [3:0] {
        MUL_NONE, MUL_SQ, MUL_DB, MUL_HI, MUL_T2, MUL_KH, MUL_QN, MUL_ENV,
        MUL_EOCT, MUL_ROOT, MUL_MK, MUL_WET, MUL_LEFT, MUL_RIGHT
    } t_mul_sel;

    // Register update selection
    typedef enum logic [4:0] {
        UPD_NONE, UPD_LOAD, UPD_NORM, UPD_SQ, UPD_LVL, UPD_TGT_HI, UPD_Q,
        UPD_TGT_MID, UPD_ENV, UPD_EOCT, UPD_ROOT, UPD_GAIN, UPD_GM, UPD_COEF,
        UPD_LEFT, UPD_RIGHT, UPD_EMIT
    } t_upd;

    typedef struct packed {
        t_mul_sel    mul;
        t_upd        upd;
        logic [4:0]  k;
    } t_cmd;

    typedef struct packed {
        logic knee_hi;
        logic knee_mid;
        logic out_busy;
    } t_status;

    typedef logic [16:0][31:0] t_root_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res = '0;
        rem = v;
        for (int i = 31; i >= 0; i--) begin
            bitv = 64'd1 << (2 * i);
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // Q2.30 values of 2^(2^-k), by repeated square roots
    function automatic t_root_tab build_roots();
        t_root_tab   t;
        logic [63:0] r;
        r    = 64'd1 << 31;
        t[0] = r[31:0];
        for (int k = 1; k < 17; k++) begin
            r    = isqrt64(r << 30);
            t[k] = r[31:0];
        end
        return t;
    endfunction

    localparam t_root_tab ROOT_TAB = build_roots();

endpackage
`default_nettype wire

// File: rtl/skac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module skac_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  skac_pkg::t_status      i_status,
    output skac_pkg::t_cmd         o_cmd
);
    import skac_pkg::*;

    typedef enum logic [27:0] {
        S_IDLE    = 28'h0000001,
        S_NORM    = 28'h0000002,
        S_SQ_MUL  = 28'h0000004,
        S_SQ_UPD  = 28'h0000008,
        S_DB_MUL  = 28'h0000010,
        S_LVL     = 28'h0000020,
        S_BRANCH  = 28'h0000040,
        S_HI_UPD  = 28'h0000080,
        S_KH_MUL  = 28'h0000100,
        S_Q_UPD   = 28'h0000200,
        S_QN_MUL  = 28'h0000400,
        S_MID_UPD = 28'h0000800,
        S_ENV_MUL = 28'h0001000,
        S_ENV_UPD = 28'h0002000,
        S_E_MUL   = 28'h0004000,
        S_E_UPD   = 28'h0008000,
        S_RT_MUL  = 28'h0010000,
        S_RT_UPD  = 28'h0020000,
        S_GAIN    = 28'h0040000,
        S_MK_MUL  = 28'h0080000,
        S_GM_UPD  = 28'h0100000,
        S_WT_MUL  = 28'h0200000,
        S_COEF    = 28'h0400000,
        S_LO_MUL  = 28'h0800000,
        S_LO_UPD  = 28'h1000000,
        S_RO_MUL  = 28'h2000000,
        S_RO_UPD  = 28'h4000000,
        S_EMIT    = 28'h8000000
    } t_state;

    localparam logic [4:0] SQ_LAST   = 5'd15;
    localparam logic [4:0] ROOT_LAST = 5'd16;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    assign o_in_stall = (r_state != S_IDLE);

    // Sequence one frame through the shared multiplier
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd.mul = MUL_NONE;
        o_cmd.upd = UPD_NONE;
        o_cmd.k   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.upd = UPD_LOAD;
                    n_state   = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.upd = UPD_NORM;
                n_cnt     = '0;
                n_state   = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                o_cmd.mul = MUL_SQ;
                n_state   = S_SQ_UPD;
            end
            S_SQ_UPD: begin
                o_cmd.upd = UPD_SQ;
                if (r_cnt == SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DB_MUL;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_DB_MUL: begin
                o_cmd.mul = MUL_DB;
                n_state   = S_LVL;
            end
            S_LVL: begin
                o_cmd.upd = UPD_LVL;
                n_state   = S_BRANCH;
            end
            S_BRANCH: begin
                if (i_status.knee_hi) begin
                    o_cmd.mul = MUL_HI;
                    n_state   = S_HI_UPD;
                end else if (i_status.knee_mid) begin
                    o_cmd.mul = MUL_T2;
                    n_state   = S_KH_MUL;
                end else begin
                    n_state   = S_ENV_MUL;
                end
            end
            S_HI_UPD: begin
                o_cmd.upd = UPD_TGT_HI;
                n_state   = S_ENV_MUL;
            end
            S_KH_MUL: begin
                o_cmd.mul = MUL_KH;
                n_state   = S_Q_UPD;
            end
            S_Q_UPD: begin
                o_cmd.upd = UPD_Q;
                n_state   = S_QN_MUL;
            end
            S_QN_MUL: begin
                o_cmd.mul = MUL_QN;
                n_state   = S_MID_UPD;
            end
            S_MID_UPD: begin
                o_cmd.upd = UPD_TGT_MID;
                n_state   = S_ENV_MUL;
            end
            S_ENV_MUL: begin
                o_cmd.mul = MUL_ENV;
                n_state   = S_ENV_UPD;
            end
            S_ENV_UPD: begin
                o_cmd.upd = UPD_ENV;
                n_state   = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.mul = MUL_EOCT;
                n_state   = S_E_UPD;
            end
            S_E_UPD: begin
                o_cmd.upd = UPD_EOCT;
                n_cnt     = '0;
                n_state   = S_RT_MUL;
            end
            S_RT_MUL: begin
                o_cmd.mul = MUL_ROOT;
                n_state   = S_RT_UPD;
            end
            S_RT_UPD: begin
                o_cmd.upd = UPD_ROOT;
                if (r_cnt == ROOT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_GAIN;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_RT_MUL;
                end
            end
            S_GAIN: begin
                o_cmd.upd = UPD_GAIN;
                n_state   = S_MK_MUL;
            end
            S_MK_MUL: begin
                o_cmd.mul = MUL_MK;
                n_state   = S_GM_UPD;
            end
            S_GM_UPD: begin
                o_cmd.upd = UPD_GM;
                n_state   = S_WT_MUL;
            end
            S_WT_MUL: begin
                o_cmd.mul = MUL_WET;
                n_state   = S_COEF;
            end
            S_COEF: begin
                o_cmd.upd = UPD_COEF;
                n_state   = S_LO_MUL;
            end
            S_LO_MUL: begin
                o_cmd.mul = MUL_LEFT;
                n_state   = S_LO_UPD;
            end
            S_LO_UPD: begin
                o_cmd.upd = UPD_LEFT;
                n_state   = S_RO_MUL;
            end
            S_RO_MUL: begin
                o_cmd.mul = MUL_RIGHT;
                n_state   = S_RO_UPD;
            end
            S_RO_UPD: begin
                o_cmd.upd = UPD_RIGHT;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.upd = UPD_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: rtl/skac_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module skac_dp #(
    parameter int DB_TABLE_ENTRIES = skac_pkg::DB_TABLE_ENTRIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  skac_pkg::t_cmd                         i_cmd,
    input  skac_pkg::t_in_word                     i_in_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [skac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [skac_pkg::CFG_W-1:0]        i_cfg_data,
    output skac_pkg::t_status                      o_status,
    output logic                                   o_out_valid,
    output skac_pkg::t_out_word                    o_out_word,
    input  wire logic                              i_out_stall
);
    import skac_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int LOGN  = $clog2(DB_TABLE_ENTRIES);
    localparam int PW    = $clog2(SB);
    localparam int MW    = PW + 16;
    localparam int AW    = 34;
    localparam int BW    = 32;
    localparam int PRW   = AW + BW;
    localparam logic [45:0] POS_MAX = (46'd1 << (SB - 1)) - 46'd1;
    localparam logic [45:0] NEG_MAG = 46'd1 << (SB - 1);

    // Configuration registers
    logic signed [14:0] r_thr;
    logic [12:0]        r_knee;
    logic [21:0]        r_khi;
    logic signed [15:0] r_slope;
    logic [23:0]        r_atk, r_rel;
    logic [24:0]        r_mkp;
    logic [16:0]        r_wet;

    // Working registers
    logic signed [SB-1:0] r_l, r_r;
    logic                 r_be;
    logic [SB-1:0]        r_det;
    logic                 r_zero;
    logic [PW-1:0]        r_oct;
    logic [30:0]          r_x;
    logic [15:0]          r_log;
    logic signed [16:0]   r_over;
    logic [23:0]          r_target;
    logic [AW-1:0]        r_q;
    logic [23:0]          r_env, r_runmax;
    logic [15:0]          r_now, r_bm;
    logic [5:0]           r_n;
    logic [16:0]          r_h;
    logic [31:0]          r_pw, r_gain;
    logic [27:0]          r_gm;
    logic [29:0]          r_coef;
    logic [SB-1:0]        r_lo, r_ro;
    logic [PRW-1:0]       r_prod;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    // Shared derived values
    logic [12:0]          knee_eff;
    logic signed [17:0]   two_over, knee_s, t2;
    logic [15:0]          ns;
    logic [16:0]          wet_eff;
    logic [MW-1:0]        oct_q16, m_val;
    logic [23:0]          env_coef, env_diff;
    logic [AW-1:0]        mul_a;
    logic [BW-1:0]        mul_b;

    function automatic logic [23:0] sat24(input logic [PRW-1:0] v);
        return (v > PRW'(24'hFFFFFF)) ? 24'hFFFFFF : v[23:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [24:0] v);
        logic [24:0] s;
        s = (v + 25'd128) >> 8;
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [SB-1:0] mag(input logic [SB-1:0] v);
        return v[SB-1] ? (~v + SB'(1)) : v;
    endfunction

    function automatic logic [SB-1:0] scale(input logic sgn, input logic [PRW-1:0] p);
        logic [45:0] rr;
        rr = 46'((p + PRW'(1 << 19)) >> 20);
        if (!sgn) begin
            return (rr > POS_MAX) ? POS_MAX[SB-1:0] : rr[SB-1:0];
        end
        return (rr >= NEG_MAG) ? NEG_MAG[SB-1:0] : (~rr[SB-1:0] + SB'(1));
    endfunction

    // Knee and slope terms, with wet clamp, octave offset and envelope coefficient
    always_comb begin
        knee_eff = (r_knee < KNEE_MIN_Q8) ? KNEE_MIN_Q8 : r_knee;
        two_over = {r_over, 1'b0};
        knee_s   = $signed({5'b0, knee_eff});
        t2       = two_over + knee_s;
        ns       = r_slope[15] ? (~r_slope + 16'd1) : 16'd0;
        wet_eff  = (r_wet > 17'd65536) ? 17'd65536 : r_wet;
        oct_q16  = {r_oct, 16'b0};
        m_val    = (oct_q16 > MW'(r_log)) ? (oct_q16 - MW'(r_log)) : '0;
        env_coef = (r_target > r_env) ? r_atk : r_rel;
        env_diff = (r_env > r_target) ? (r_env - r_target) : (r_target - r_env);
    end

    assign o_status.knee_hi  = (two_over > knee_s);
    assign o_status.knee_mid = (two_over > -knee_s);
    assign o_status.out_busy = r_out_valid & i_out_stall;

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul)
            MUL_SQ:    begin mul_a = AW'(r_x);           mul_b = BW'(r_x);          end
            MUL_DB:    begin mul_a = AW'(m_val);         mul_b = DB_PER_OCTAVE_Q16; end
            MUL_HI:    begin mul_a = AW'(ns);            mul_b = BW'(r_over[15:0]); end
            MUL_T2:    begin mul_a = AW'(t2[14:0]);      mul_b = BW'(t2[14:0]);     end
            MUL_KH:    begin mul_a = AW'(r_prod[29:0]);  mul_b = BW'(r_khi);        end
            MUL_QN:    begin mul_a = r_q;                mul_b = BW'(ns);           end
            MUL_ENV:   begin mul_a = AW'(env_coef);      mul_b = BW'(env_diff);     end
            MUL_EOCT:  begin mul_a = AW'(r_env);         mul_b = OCTAVE_PER_DB_Q24; end
            MUL_ROOT:  begin mul_a = AW'(r_pw);          mul_b = ROOT_TAB[i_cmd.k]; end
            MUL_MK:    begin mul_a = AW'(r_gain);        mul_b = BW'(r_mkp);        end
            MUL_WET:   begin mul_a = AW'(r_gm);          mul_b = BW'(wet_eff);      end
            MUL_LEFT:  begin mul_a = AW'(mag(r_l));      mul_b = BW'(r_coef);       end
            MUL_RIGHT: begin mul_a = AW'(mag(r_r));      mul_b = BW'(r_coef);       end
            default:   begin mul_a = '0;                 mul_b = '0;                end
        endcase
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= PRW'(mul_a) * PRW'(mul_b);
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RST_THRESHOLD;
            r_knee  <= RST_KNEE;
            r_khi   <= RST_KNEE_INV;
            r_slope <= RST_SLOPE;
            r_atk   <= RST_ATTACK;
            r_rel   <= RST_RELEASE;
            r_mkp   <= RST_MAKEUP;
            r_wet   <= RST_WET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr   <= i_cfg_data[14:0];
                CFG_KNEE:      r_knee  <= i_cfg_data[12:0];
                CFG_KNEE_INV:  r_khi   <= i_cfg_data[21:0];
                CFG_SLOPE:     r_slope <= i_cfg_data[15:0];
                CFG_ATTACK:    r_atk   <= i_cfg_data[23:0];
                CFG_RELEASE:   r_rel   <= i_cfg_data[23:0];
                CFG_MAKEUP:    r_mkp   <= i_cfg_data[24:0];
                CFG_WET:       r_wet   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Update working registers per step
    logic signed [SB-1:0] det_a, det_b;
    logic [SB-1:0]        mag_a, mag_b, nd;
    logic [PW-1:0]        msb;
    logic [31:0]          sq;
    logic [16:0]          db_mag;
    logic [14:0]          lvl_mag;
    logic [24:0]          delta, env_sum;
    logic [23:0]          env_new, rm_new;
    logic [21:0]          e_val;
    logic [6:0]           n_one;
    logic [4:0]           hbit;

    always_comb begin
        det_a = i_in_word.use_key ? i_in_word.key_left  : i_in_word.left_sample;
        det_b = i_in_word.use_key ? i_in_word.key_right : i_in_word.right_sample;
        mag_a = mag(det_a);
        mag_b = mag(det_b);
        msb   = '0;
        for (int i = 0; i < SB; i++) begin
            if (r_det[i]) msb = PW'(i);
        end
        nd      = r_det << (PW'(SB - 1) - msb);
        sq      = r_prod[61:30];
        db_mag  = 17'((r_prod + PRW'(1 << 23)) >> 24);
        lvl_mag = (r_zero || db_mag > 17'(FLOOR_DB_MAG_Q8)) ? FLOOR_DB_MAG_Q8
                                                             : db_mag[14:0];
        delta   = 25'((r_prod + PRW'(1 << 23)) >> 24);
        env_sum = (r_env > r_target) ? (25'(r_target) + delta)
                                     : (25'(r_target) - delta);
        env_new = env_sum[23:0];
        rm_new  = (env_new > r_runmax) ? env_new : r_runmax;
        e_val   = 22'((r_prod + PRW'(1 << 23)) >> 24);
        n_one   = 7'(r_n) + 7'd1;
        hbit    = 5'd16 - i_cmd.k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env    <= '0;
            r_runmax <= '0;
        end else begin
            case (i_cmd.upd)
                UPD_LOAD: begin
                    r_l   <= i_in_word.left_sample;
                    r_r   <= i_in_word.right_sample;
                    r_be  <= i_in_word.block_end;
                    r_det <= (mag_a > mag_b) ? mag_a : mag_b;
                end
                UPD_NORM: begin
                    r_zero <= (r_det == '0);
                    r_oct  <= PW'(SB - 1) - msb;
                    r_x    <= {1'b1, nd[SB-2 -: LOGN], {(30 - LOGN){1'b0}}};
                    r_log  <= '0;
                end
                UPD_SQ: begin
                    r_x   <= sq[31] ? sq[31:1] : sq[30:0];
                    r_log <= {r_log[14:0], sq[31]};
                end
                UPD_LVL: begin
                    r_over   <= 17'sd0 - $signed({2'b00, lvl_mag}) - 17'(r_thr);
                    r_target <= '0;
                end
                UPD_TGT_HI:  r_target <= sat24((r_prod + PRW'(64)) >> 7);
                UPD_Q:       r_q      <= AW'((r_prod + PRW'(1 << 17)) >> 18);
                UPD_TGT_MID: r_target <= sat24((r_prod + PRW'(1 << 14)) >> 15);
                UPD_ENV: begin
                    r_env    <= env_new;
                    r_now    <= sat16(25'(env_new));
                    r_bm     <= r_be ? sat16(25'(rm_new)) : 16'd0;
                    r_runmax <= r_be ? 24'd0 : rm_new;
                end
                UPD_EOCT: begin
                    r_n  <= e_val[21:16];
                    r_h  <= 17'h10000 - {1'b0, e_val[15:0]};
                    r_pw <= 32'd1 << 30;
                end
                UPD_ROOT: begin
                    if (r_h[hbit]) r_pw <= 32'((r_prod + PRW'(1 << 29)) >> 30);
                end
                UPD_GAIN:  r_gain <= (n_one >= 7'd63) ? 32'd0 : (r_pw >> n_one);
                UPD_GM:    r_gm   <= 28'((r_prod + PRW'(1 << 29)) >> 30);
                UPD_COEF:  r_coef <= 30'((r_prod + PRW'(1 << 15)) >> 16)
                                     + 30'({17'h10000 - wet_eff, 4'b0});
                UPD_LEFT:  r_lo   <= scale(r_l[SB-1], r_prod);
                UPD_RIGHT: r_ro   <= scale(r_r[SB-1], r_prod);
                default: ;
            endcase
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd == UPD_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd == UPD_EMIT) begin
            r_out_word.left_out            <= r_lo;
            r_out_word.right_out           <= r_ro;
            r_out_word.reduction_now       <= r_now;
            r_out_word.block_max_reduction <= r_bm;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

// File: rtl/soft_knee_audio_compressor.sv
`timescale 1ns / 1ps
`default_nettype none
// Stereo soft-knee compressor, one frame per word. Each word runs through the
// single shared 34x32 multiplier, which carries a 16-step log2 by repeated
// squaring and a 17-step 2^-x product of roots; the gain target takes no
// multiply below the knee, one above it and three inside it. Input is stalled
// while a frame is in work, so a new word is not taken before the last is
// through; it can be accepted as soon as the result word is valid. While the
// previous result is still held by a stall on the result side, the next result
// is not issued. A finished result waits in the output register while the next
// word is accepted. The user must write configuration through a plain indexed
// port only while the block is idle; the block itself does not enforce this.
module soft_knee_audio_compressor #(
    parameter int DB_TABLE_ENTRIES = skac_pkg::DB_TABLE_ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  skac_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output skac_pkg::t_out_word                 o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [skac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [skac_pkg::CFG_W-1:0]     i_cfg_data
);
    import skac_pkg::*;

    t_cmd    cmd;
    t_status status;

    skac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    skac_dp #(
        .DB_TABLE_ENTRIES (DB_TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    // Accepting a word starts work and closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // A new result comes only out of a frame in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a frame in work");

    // Input opens in the cycle after a result is issued
    a_idle_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still stalled after result issued");

endmodule
`default_nettype wire

// File: bench/soft_knee_audio_compressor_test.sv
`timescale 1ns / 1ps
module soft_knee_audio_compressor_test;
    import skac_pkg::*;

    typedef longint unsigned u64;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    t_in_word        in_word = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out_word       out_word;
    logic            cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    soft_knee_audio_compressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of registers and state
    logic [14:0] thr_reg;
    logic [12:0] knee_reg;
    logic [21:0] knee_inv_reg;
    logic [15:0] slope_reg;
    logic [23:0] attack_reg;
    logic [23:0] release_reg;
    logic [24:0] makeup_reg;
    logic [16:0] wet_reg;
    u64          envelope_q16;
    u64          peak_q16;
    u64          log2_frac [1024];
    u64          octave_root [17];

    t_in_word    frame_q [$];
    t_out_word   expected_q [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int unsigned cyc = 0;

    function automatic u64 int_sqrt(u64 v);
        u64 res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic build_tables();
        u64 x, r;
        for (int i = 0; i < 1024; i++) begin
            x = (u64'(1) << 30) + ((u64'(i) << 30) / 1024);
            r = 0;
            for (int b = 0; b < 16; b++) begin
                x = (x * x) >> 30;
                r = r << 1;
                if (x >= (u64'(2) << 30)) begin
                    x = x >> 1;
                    r = r | 1;
                end
            end
            log2_frac[i] = r;
        end
        octave_root[0] = u64'(1) << 31;
        for (int k = 1; k < 17; k++) octave_root[k] = int_sqrt(octave_root[k-1] << 30);
    endtask

    task automatic reset_predictor();
        thr_reg = RST_THRESHOLD;
        knee_reg = RST_KNEE;
        knee_inv_reg = RST_KNEE_INV;
        slope_reg = RST_SLOPE;
        attack_reg = RST_ATTACK;
        release_reg = RST_RELEASE;
        makeup_reg = RST_MAKEUP;
        wet_reg = RST_WET;
        envelope_q16 = 0;
        peak_q16 = 0;
    endtask

    // Detector magnitude to dB Q8.8, floored at -120 dB
    function automatic longint level_db(u64 d);
        int p;
        u64 idx, m, db;
        longint lv;
        if (d == 0) return -30720;
        p = 31;
        while (p > 0 && !d[p]) p--;
        idx = ((d - (u64'(1) << p)) * 1024) >> p;
        if (idx >= 1024) idx = 1023;
        if (p > 23) p = 23;
        m = u64'(23 - p) * 65536;
        m = (m > log2_frac[idx]) ? m - log2_frac[idx] : 0;
        db = (m * 394566 + (u64'(1) << 23)) >> 24;
        lv = -longint'(db);
        return (lv < -30720) ? -30720 : lv;
    endfunction

    // Linear gain of an envelope in dB, Q2.30
    function automatic u64 gain_of(u64 env);
        u64 e, n, h, p;
        e = (env * 2786635 + (u64'(1) << 23)) >> 24;
        n = e >> 16;
        h = 65536 - (e & 16'hFFFF);
        p = u64'(1) << 30;
        for (int k = 0; k < 17; k++)
            if ((h >> (16 - k)) & 1) p = (p * octave_root[k] + (u64'(1) << 29)) >> 30;
        if (n + 1 >= 63) return 0;
        return p >> (n + 1);
    endfunction

    function automatic logic [23:0] apply_gain(longint x, u64 coef);
        u64 r, mag;
        longint y;
        mag = (x < 0) ? u64'(-x) : u64'(x);
        r = (mag * coef + (u64'(1) << 19)) >> 20;
        if (r > 64'd8388608) r = 64'd8388608;
        y = (x < 0) ? -longint'(r) : longint'(r);
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        return y[23:0];
    endfunction

    // Advance the envelope by one frame and form the expected word
    function automatic t_out_word compress_frame(t_in_word w);
        longint l, r, a, b, over, knee, slope;
        u64 da, db, d, ns, target, t2, q, c, diff, delta, gm, wet, coef, v;
        t_out_word o;
        l = $signed(w.left_sample);
        r = $signed(w.right_sample);
        a = w.use_key ? longint'($signed(w.key_left)) : l;
        b = w.use_key ? longint'($signed(w.key_right)) : r;
        da = (a < 0) ? u64'(-a) : u64'(a);
        db = (b < 0) ? u64'(-b) : u64'(b);
        d = (da > db) ? da : db;
        over = level_db(d) - longint'($signed(thr_reg));
        knee = (knee_reg < 3) ? 3 : longint'(knee_reg);
        slope = $signed(slope_reg);
        if (slope > 0) slope = 0;
        ns = u64'(-slope);
        if (2 * over > knee) begin
            target = (ns * u64'(over) + 64) >> 7;
        end else if (2 * over > -knee) begin
            t2 = u64'(2 * over + knee);
            q = (t2 * t2 * knee_inv_reg + (u64'(1) << 17)) >> 18;
            target = (q * ns + (u64'(1) << 14)) >> 15;
        end else begin
            target = 0;
        end
        if (target > 64'hFFFFFF) target = 64'hFFFFFF;
        c = (target > envelope_q16) ? attack_reg : release_reg;
        diff = (envelope_q16 > target) ? envelope_q16 - target : target - envelope_q16;
        delta = (c * diff + (u64'(1) << 23)) >> 24;
        v = (envelope_q16 > target) ? target + delta : target - delta;
        envelope_q16 = v & 64'hFFFFFF;
        if (envelope_q16 > peak_q16) peak_q16 = envelope_q16;
        v = (envelope_q16 + 128) >> 8;
        o.reduction_now = (v > 65535) ? 16'hFFFF : v[15:0];
        o.block_max_reduction = '0;
        if (w.block_end) begin
            v = (peak_q16 + 128) >> 8;
            o.block_max_reduction = (v > 65535) ? 16'hFFFF : v[15:0];
            peak_q16 = 0;
        end
        gm = (gain_of(envelope_q16) * makeup_reg + (u64'(1) << 29)) >> 30;
        wet = (wet_reg > 65536) ? 65536 : wet_reg;
        coef = ((gm * wet + (u64'(1) << 15)) >> 16) + ((65536 - wet) << 4);
        o.left_out = apply_gain(l, coef);
        o.right_out = apply_gain(r, coef);
        return o;
    endfunction

    // Drive input words in bursts with gaps
    always @(posedge i_clk) begin
        logic accepted;
        accepted = in_valid && !in_stall;
        if (accepted) begin
            expected_q.push_back(compress_frame(in_word));
            void'(frame_q.pop_front());
        end
        if (!in_valid || accepted) begin
            if (gap_left > 0 || frame_q.size() == 0) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_word <= frame_q[0];
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
                end
            end
        end
    end

    // Stall the output on a changing pattern and check each result word
    always @(posedge i_clk) begin
        t_out_word exp_w;
        cyc <= cyc + 1;
        case (cyc[9:8])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= $urandom_range(0, 1);
            2'd2: out_stall <= (cyc[5:0] < 40);
            default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
        if (out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", out_word);
            end else begin
                exp_w = expected_q.pop_front();
                if (out_word.left_out !== exp_w.left_out ||
                    out_word.right_out !== exp_w.right_out ||
                    out_word.reduction_now !== exp_w.reduction_now ||
                    out_word.block_max_reduction !== exp_w.block_max_reduction) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp L=%h R=%h now=%h max=%h, got L=%h R=%h now=%h max=%h",
                                 exp_w.left_out, exp_w.right_out, exp_w.reduction_now,
                                 exp_w.block_max_reduction, out_word.left_out,
                                 out_word.right_out, out_word.reduction_now,
                                 out_word.block_max_reduction);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_THRESHOLD: thr_reg = data[14:0];
            CFG_KNEE:      knee_reg = data[12:0];
            CFG_KNEE_INV:  knee_inv_reg = data[21:0];
            CFG_SLOPE:     slope_reg = data[15:0];
            CFG_ATTACK:    attack_reg = data[23:0];
            CFG_RELEASE:   release_reg = data[23:0];
            CFG_MAKEUP:    makeup_reg = data[24:0];
            default:       wet_reg = data[16:0];
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every expected word has come back
    task automatic drain();
        while (frame_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
        if ($urandom_range(0, 19) == 0) v = $urandom;
        return v[23:0];
    endfunction

    task automatic push_frame(int l, int r, int kl, int kr, bit uk, bit be);
        t_in_word w;
        w.left_sample = l[23:0];
        w.right_sample = r[23:0];
        w.key_left = kl[23:0];
        w.key_right = kr[23:0];
        w.use_key = uk;
        w.block_end = be;
        frame_q.push_back(w);
    endtask

    initial begin
        int knee;
        t_in_word w;
        build_tables();
        reset_predictor();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: silence, extremes, sidechain and block ends
        push_frame(0, 0, 0, 0, 0, 0);
        push_frame(0, 0, 0, 0, 0, 1);
        push_frame(8388607, 8388607, 0, 0, 0, 0);
        push_frame(-8388608, -8388608, 0, 0, 0, 0);
        push_frame(8388607, -8388608, 0, 0, 0, 1);
        push_frame(1, -1, 0, 0, 0, 0);
        push_frame(100, 200, 8388607, -8388608, 1, 0);
        push_frame(-8388608, 8388607, 0, 0, 1, 1);
        push_frame(4194304, 2097152, 1, 1, 0, 0);
        push_frame(700000, -300000, 65536, 3000000, 1, 0);
        push_frame(2000000, 2000000, 0, 0, 0, 0);
        push_frame(3000000, 10, 0, 0, 0, 1);
        push_frame(-5, 8388607, -8388608, 0, 1, 0);
        push_frame(8388607, 8388607, 8388607, 8388607, 1, 1);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_THRESHOLD, -15360);
                    write_reg(CFG_KNEE, 0);
                    write_reg(CFG_KNEE_INV, 0);
                    write_reg(CFG_SLOPE, -32768);
                    write_reg(CFG_ATTACK, 0);
                    write_reg(CFG_RELEASE, 0);
                    write_reg(CFG_MAKEUP, 0);
                    write_reg(CFG_WET, 0);
                end
                1: begin
                    write_reg(CFG_THRESHOLD, 0);
                    write_reg(CFG_KNEE, 8191);
                    write_reg(CFG_KNEE_INV, 3276800);
                    write_reg(CFG_SLOPE, 32767);
                    write_reg(CFG_ATTACK, 24'hFFFFFF);
                    write_reg(CFG_RELEASE, 24'hFFFFFF);
                    write_reg(CFG_MAKEUP, 16777216);
                    write_reg(CFG_WET, 131071);
                end
                2: begin
                    write_reg(CFG_THRESHOLD, -15360);
                    write_reg(CFG_KNEE, 3);
                    write_reg(CFG_KNEE_INV, 22'h3FFFFF);
                    write_reg(CFG_SLOPE, -32768);
                    write_reg(CFG_ATTACK, 0);
                    write_reg(CFG_RELEASE, 24'hFFFFFF);
                    write_reg(CFG_MAKEUP, 25'h1FFFFFF);
                    write_reg(CFG_WET, 65536);
                end
                default: begin
                    knee = $urandom_range(3, 6144);
                    write_reg(CFG_THRESHOLD, -int'($urandom_range(0, 15360)));
                    write_reg(CFG_KNEE, knee);
                    write_reg(CFG_KNEE_INV, (1 << 23) / knee);
                    write_reg(CFG_SLOPE, -int'($urandom_range(0, 32768)));
                    write_reg(CFG_ATTACK, $urandom_range(24'hF00000, 24'hFFFFFF));
                    write_reg(CFG_RELEASE, $urandom_range(24'hF80000, 24'hFFFFFF));
                    write_reg(CFG_MAKEUP, $urandom_range(0, 16777216));
                    write_reg(CFG_WET, $urandom_range(0, 65536));
                end
            endcase
            for (int n = 0; n < 200; n++) begin
                w.left_sample = rand_sample();
                w.right_sample = rand_sample();
                w.key_left = rand_sample();
                w.key_right = rand_sample();
                w.use_key = ($urandom_range(0, 9) < 3);
                w.block_end = ($urandom_range(0, 15) == 0);
                frame_q.push_back(w);
            end
            drain();
        end

        repeat (120) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
